// ===== sv/blr_pkg.sv =====
package blr_pkg;

   localparam int unsigned COORD_BITS_DEFAULT = 6;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } blr_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } blr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
   } blr_status_type;

endpackage

// ===== sv/blr_ctrl.sv =====
module blr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output blr_pkg::blr_cmd_type    cmd,
   input  blr_pkg::blr_status_type status
);

   blr_pkg::blr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= blr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         blr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = blr_pkg::ST_RUN;
            end
         end
         blr_pkg::ST_RUN: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (!status.last) begin
                  cmd.step = 1'b1;
               end else begin
                  // end point taken: the next line may load in the same cycle
                  req_tready = 1'b1;
                  if (req_tvalid) begin
                     cmd.load = 1'b1;
                  end else begin
                     state_in = blr_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: state_in = blr_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== sv/blr_dpath.sv =====
module blr_dpath #(
   parameter int unsigned COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  blr_pkg::blr_cmd_type    cmd,
   output blr_pkg::blr_status_type status,
   input  logic [COORD_BITS-1:0]   x_start,
   input  logic [COORD_BITS-1:0]   y_start,
   input  logic [COORD_BITS-1:0]   x_end,
   input  logic [COORD_BITS-1:0]   y_end,
   output logic [COORD_BITS-1:0]   pixel_x,
   output logic [COORD_BITS-1:0]   pixel_y
);

   localparam int unsigned CW = COORD_BITS;
   localparam int unsigned DW = COORD_BITS + 3;
   localparam int unsigned SW = COORD_BITS + 1;

   logic [CW-1:0]        cur_x_ff, cur_x_in;
   logic [CW-1:0]        cur_y_ff, cur_y_in;
   logic signed [DW-1:0] decision_ff, decision_in;
   logic signed [DW-1:0] inc_neg_ff, inc_neg_in;
   logic signed [DW-1:0] inc_pos_ff, inc_pos_in;
   logic [SW-1:0]        steps_ff, steps_in;
   logic                 xdown_ff, xdown_in;
   logic                 ydown_ff, ydown_in;
   logic                 steep_ff, steep_in;

   logic                 xdown, ydown, steep;
   logic [CW-1:0]        delta_x, delta_y, dmaj, dmin;
   logic signed [DW-1:0] dmaj_ext, dmin2_ext;
   logic                 minor_step;
   logic [CW-1:0]        x_next, y_next;

   always_comb begin
      xdown     = x_end < x_start;
      ydown     = y_end < y_start;
      delta_x   = xdown ? x_start - x_end : x_end - x_start;
      delta_y   = ydown ? y_start - y_end : y_end - y_start;
      steep     = delta_y > delta_x;
      dmaj      = steep ? delta_y : delta_x;
      dmin      = steep ? delta_x : delta_y;
      dmaj_ext  = signed'({{(DW-CW){1'b0}}, dmaj});
      dmin2_ext = signed'({{(DW-CW-1){1'b0}}, dmin, 1'b0});

      minor_step = !decision_ff[DW-1];
      x_next     = xdown_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
      y_next     = ydown_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;

      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      decision_in = decision_ff;
      inc_neg_in  = inc_neg_ff;
      inc_pos_in  = inc_pos_ff;
      steps_in    = steps_ff;
      xdown_in    = xdown_ff;
      ydown_in    = ydown_ff;
      steep_in    = steep_ff;

      priority if (cmd.load) begin
         cur_x_in    = x_start;
         cur_y_in    = y_start;
         decision_in = dmin2_ext - dmaj_ext;
         inc_neg_in  = dmin2_ext;
         inc_pos_in  = dmin2_ext - (dmaj_ext <<< 1);
         steps_in    = {1'b0, dmaj} + 1'b1;
         xdown_in    = xdown;
         ydown_in    = ydown;
         steep_in    = steep;
      end else if (cmd.step) begin
         steps_in = steps_ff - 1'b1;
         if (steep_ff) begin
            cur_y_in = y_next;
            if (minor_step) cur_x_in = x_next;
         end else begin
            cur_x_in = x_next;
            if (minor_step) cur_y_in = y_next;
         end
         decision_in = decision_ff + (minor_step ? inc_pos_ff : inc_neg_ff);
      end else begin
         steps_in = steps_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else begin
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      decision_ff <= decision_in;
      inc_neg_ff  <= inc_neg_in;
      inc_pos_ff  <= inc_pos_in;
      xdown_ff    <= xdown_in;
      ydown_ff    <= ydown_in;
      steep_ff    <= steep_in;
   end

   assign status.last = steps_ff == SW'(1);
   assign pixel_x     = cur_x_ff;
   assign pixel_y     = cur_y_ff;

endmodule

// ===== sv/bresenham_line_rasterizer.sv =====
// Bresenham line rasterizer. Each request word carries a line's start and end
// point; the block answers with every pixel of the line, start point first and
// end point last, the end point marked by rsp_tlast. A line has
// max(|dx|,|dy|)+1 pixels, one per cycle while rsp_tready is high. A line
// taken from idle is first loaded, then shown; the next request is loaded in
// the cycle that the end point is taken, so back-to-back lines need no load
// step between them. The pixel stepper holds one line at a time and the pixel
// register is the output stage.
module bresenham_line_rasterizer #(
   parameter int unsigned COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // x_start, y_start, x_end, y_end, zero pad
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pixel_x, pixel_y, zero pad
   output logic [((2*COORD_BITS+7)/8)*8-1:0]    rsp_tdata,
   // last_pixel
   output logic                                 rsp_tlast
);

   localparam int unsigned RSP_W = ((2*COORD_BITS+7)/8)*8;

   blr_pkg::blr_cmd_type    cmd;
   blr_pkg::blr_status_type status;
   logic [COORD_BITS-1:0]   pixel_x, pixel_y;

   blr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   blr_dpath #(
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .x_start (req_tdata[COORD_BITS-1:0]),
      .y_start (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .x_end   (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .y_end   (req_tdata[4*COORD_BITS-1:3*COORD_BITS]),
      .pixel_x (pixel_x),
      .pixel_y (pixel_y)
   );

   assign rsp_tdata = RSP_W'({pixel_y, pixel_x});
   assign rsp_tlast = status.last;

endmodule

// ===== sv/blr_checker.sv =====
module blr_checker #(
   parameter int unsigned COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((2*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                              rsp_tlast
);

   // a stalled pixel holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled pixel changed");

   // a new line only starts once the previous end point leaves
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || (rsp_tready && rsp_tlast))
      else $error("line accepted while pixels pending");

   // first pixel of a line is its start point
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid
         && rsp_tdata[2*COORD_BITS-1:0] == $past(req_tdata[2*COORD_BITS-1:0]))
      else $error("first pixel is not the start point");

   // a line does not stop before its end point
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("line ended without last pixel");

endmodule

bind bresenham_line_rasterizer blr_checker #(.COORD_BITS(COORD_BITS)) u_blr_checker (.*);
